[rtl/anagram_check_by_histogram_top_macros.svh]
// Assertion macros for the checker file.
`ifndef ANAGRAM_CHECK_BY_HISTOGRAM_TOP_MACROS_SVH
`define ANAGRAM_CHECK_BY_HISTOGRAM_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ACGH_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ACGH_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

[rtl/acgh_pkg.sv]
package acgh_pkg;

  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = 8;
  localparam int TALLY_W    = 13;

  localparam logic [TALLY_W-1:0] TALLY_MAX  = 13'd8191;
  localparam logic [TALLY_W-1:0] TALLY_ZERO = 13'd0;

  // action codes
  localparam logic ACT_FIRST  = 1'b0;
  localparam logic ACT_SECOND = 1'b1;

  // one result item, is_permutation in the lowest bit
  typedef struct packed {
    logic too_long;
    logic is_permutation;
  } result_t;

endpackage

[rtl/acgh_ram.sv]
module acgh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/acgh_outq.sv]
module acgh_outq import acgh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  result_t    push_data,
  input  logic       pop_ready,
  output logic       pop_valid,
  output result_t    pop_data,
  output logic [2:0] count
);

  result_t    slot_r [4];
  logic [1:0] wr_ptr_r, wr_ptr_nxt;
  logic [1:0] rd_ptr_r, rd_ptr_nxt;
  logic [2:0] count_r, count_nxt;
  logic       pop;

  assign pop_valid = (count_r != 3'd0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign count     = count_r;
  assign pop       = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 2'd1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 2'd1 : rd_ptr_r;
    count_nxt  = count_r + {2'b0, push} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/anagram_check_by_histogram_top.sv]
// Anagram check by character histogram.
//
// Input stream: one byte per transfer. in_tuser[0] is action (0 = first string,
// 1 = second string), in_tuser[1] is has_char (0 marks an item without a character),
// in_tdata carries the byte and in_tlast closes the current string.
// First-string bytes count up a 256-entry histogram, second-string bytes count
// it down; a transfer with action 1 and tlast 1 yields one result transfer:
// out_tdata[0] is_permutation, out_tdata[1] too_long.
// Throughput: one input transfer per cycle while in_tready is high. Each byte
// is one read-modify-write of the histogram RAM: read issued at acceptance,
// update and write-back in the following cycle, with a one-entry forwarding
// register covering back-to-back bytes that hit the same entry.
// Result path: a closing transfer is registered in stage one, then pushed into
// the output queue, whose count raises out_tvalid.
// Stall: results wait in a four-entry output queue. in_tready drops only while
// the queue plus an in-flight closing item would leave no room for one more
// result, so a stalled receiver stops the input after at most four pending
// results.
// Reset: counters, flags and per-entry used bits clear on the synchronous reset;
// no clearing pass over the RAM is needed. The used bits also clear together
// after each result, starting the next pair from an empty histogram.
module anagram_check_by_histogram_top import acgh_pkg::*; #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic [1:0] in_tuser,   // [0] action, [1] has_char
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata   // [0] is_permutation, [1] too_long, [7:2] zero
);

  localparam int LEN_W = $clog2(MAX_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_CAP   = LEN_W'(MAX_LEN);
  localparam logic [8:0]       ALPHA_LIM = 9'(ALPHABET);
  localparam logic [IDX_W-1:0] ALPHA_TOP = IDX_W'(ALPHABET - 1);

  // input decode
  logic             accept;
  logic [IDX_W-1:0] in_idx;

  // stage one: item whose RAM read is in flight
  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_idx_r;
  logic             s1_action_r;
  logic             s1_has_r;
  logic             s1_last_r;
  logic             s1_pend;

  // histogram RAM
  logic [TALLY_W-1:0] ram_rdata;

  // forwarding of the previous cycle's write
  logic               fwd_valid_r, fwd_valid_nxt;
  logic [IDX_W-1:0]   fwd_idx_r;
  logic [TALLY_W-1:0] fwd_data_r;

  // pair state
  logic [TABLE_SIZE-1:0] used_r, used_nxt;
  logic [LEN_W-1:0]      first_len_r, first_len_nxt;
  logic [LEN_W-1:0]      second_len_r, second_len_nxt;
  logic                  mismatch_r, mismatch_nxt;
  logic                  overflow_r, overflow_nxt;

  // stage two update
  logic               upd;
  logic               emit;
  logic [TALLY_W-1:0] cur_raw;
  logic [TALLY_W-1:0] cur;
  logic [TALLY_W-1:0] tally_new;
  logic [LEN_W-1:0]   first_upd, second_upd;
  logic               mismatch_upd, overflow_upd;
  result_t            res;

  // output queue
  logic [2:0] q_count;
  result_t    q_data;

  // Hold off input only when the queue cannot take every result in flight.
  assign s1_pend   = s1_valid_r && (s1_action_r == ACT_SECOND) && s1_last_r;
  assign in_tready = ({1'b0, q_count} + {3'b0, s1_pend}) < 4'd4;
  assign accept    = in_tvalid && in_tready;

  // Saturate bytes outside the alphabet to its top entry.
  assign in_idx = ({1'b0, in_tdata} >= ALPHA_LIM) ? ALPHA_TOP : in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_idx_r    <= in_idx;
      s1_action_r <= in_tuser[0];
      s1_has_r    <= in_tuser[1];
      s1_last_r   <= in_tlast;
    end
  end

  assign upd  = s1_valid_r && s1_has_r;
  assign emit = s1_valid_r && (s1_action_r == ACT_SECOND) && s1_last_r;

  acgh_ram #(
    .WIDTH (TALLY_W),
    .DEPTH (TABLE_SIZE)
  ) u_tally_ram (
    .clk   (clk),
    .we    (upd),
    .waddr (s1_idx_r),
    .wdata (tally_new),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    // Take the previous write when it hit the same entry; the RAM read missed it.
    cur_raw = (fwd_valid_r && (fwd_idx_r == s1_idx_r)) ? fwd_data_r : ram_rdata;
    // An entry not touched since the last clear reads as zero.
    cur = used_r[s1_idx_r] ? cur_raw : TALLY_ZERO;

    tally_new    = cur;
    first_upd    = first_len_r;
    second_upd   = second_len_r;
    mismatch_upd = mismatch_r;
    overflow_upd = overflow_r;

    if (upd) begin
      if (s1_action_r == ACT_FIRST) begin
        if (cur != TALLY_MAX) begin
          tally_new = cur + TALLY_W'(1);
        end
        if (first_len_r >= LEN_CAP) begin
          overflow_upd = 1'b1;
          first_upd    = LEN_CAP;
        end else begin
          first_upd = first_len_r + LEN_W'(1);
        end
      end else begin
        if (cur == TALLY_ZERO) begin
          mismatch_upd = 1'b1;
        end else begin
          tally_new = cur - TALLY_W'(1);
        end
        if (second_len_r >= LEN_CAP) begin
          overflow_upd = 1'b1;
          second_upd   = LEN_CAP;
        end else begin
          second_upd = second_len_r + LEN_W'(1);
        end
      end
    end

    res.is_permutation = !mismatch_upd && !overflow_upd && (first_upd == second_upd);
    res.too_long       = overflow_upd;

    // A result ends the pair: drop every tally and counter.
    if (emit) begin
      used_nxt       = '0;
      first_len_nxt  = '0;
      second_len_nxt = '0;
      mismatch_nxt   = 1'b0;
      overflow_nxt   = 1'b0;
      fwd_valid_nxt  = 1'b0;
    end else begin
      used_nxt = used_r;
      if (upd) begin
        used_nxt[s1_idx_r] = 1'b1;
      end
      first_len_nxt  = first_upd;
      second_len_nxt = second_upd;
      mismatch_nxt   = mismatch_upd;
      overflow_nxt   = overflow_upd;
      fwd_valid_nxt  = upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r       <= '0;
      first_len_r  <= '0;
      second_len_r <= '0;
      mismatch_r   <= 1'b0;
      overflow_r   <= 1'b0;
      fwd_valid_r  <= 1'b0;
    end else begin
      used_r       <= used_nxt;
      first_len_r  <= first_len_nxt;
      second_len_r <= second_len_nxt;
      mismatch_r   <= mismatch_nxt;
      overflow_r   <= overflow_nxt;
      fwd_valid_r  <= fwd_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      fwd_idx_r  <= s1_idx_r;
      fwd_data_r <= tally_new;
    end
  end

  acgh_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (emit),
    .push_data (res),
    .pop_ready (out_tready),
    .pop_valid (out_tvalid),
    .pop_data  (q_data),
    .count     (q_count)
  );

  assign out_tdata = {6'b0, q_data};

endmodule

[rtl/acgh_checker.sv]
`include "anagram_check_by_histogram_top_macros.svh"

module acgh_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic [1:0] in_tuser,
  input logic       in_tlast,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  logic in_close;

  assign in_close = in_tvalid && in_tready && in_tuser[0] && in_tlast;

  // an overlong pair is never reported as a permutation
  `ACGH_ASSERT_NOW(a_too_long_false, clk, rst_n, out_tvalid && out_tdata[1], !out_tdata[0])

  // a stalled result holds
  `ACGH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // a fresh result follows an accepted closing transfer
  `ACGH_ASSERT_NOW(a_out_origin, clk, rst_n, $rose(out_tvalid), $past(in_close, 2))

  // input back-pressure only comes from pending results
  `ACGH_ASSERT_NOW(a_ready_cause, clk, rst_n, !in_tready, out_tvalid)

endmodule

bind anagram_check_by_histogram_top acgh_checker u_acgh_checker (.*);

[tb/anagram_verdict_monitor.sv]
// Watches both channels of the anagram checker, keeps its own histogram and
// predicts each verdict, then compares it with what comes out.
module anagram_verdict_monitor import acgh_pkg::*; #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_byte
  input  logic [1:0] in_tuser,   // [0] action, [1] has_char
  input  logic       in_tlast,
  input  logic       out_tvalid,
  input  logic       out_tready,
  input  logic [7:0] out_tdata,  // [0] is_permutation, [1] too_long, [7:2] zero
  output int         mismatches,
  output int         awaiting
);

  logic [TALLY_W-1:0] tally [TABLE_SIZE];
  logic               used  [TABLE_SIZE];
  int unsigned        len_first;
  int unsigned        len_second;
  logic               went_negative;
  logic               overflow;
  result_t            verdicts [$];

  function automatic void clear_pair();
    for (int i = 0; i < TABLE_SIZE; i++) begin
      tally[i] = TALLY_ZERO;
      used[i]  = 1'b0;
    end
    len_first     = 0;
    len_second    = 0;
    went_negative = 1'b0;
    overflow      = 1'b0;
  endfunction

  // Count one more byte; hold at the limit and flag the overflow.
  function automatic int unsigned bump_len(int unsigned n);
    if (n >= MAX_LEN) begin
      overflow = 1'b1;
      return MAX_LEN;
    end
    return n + 1;
  endfunction

  function automatic void tally_char(logic act, logic [7:0] ch, logic has, logic lst);
    int unsigned        idx;
    logic [TALLY_W-1:0] cur;
    result_t            v;
    if (has) begin
      idx = ch;
      if (idx >= ALPHABET) idx = ALPHABET - 1;
      cur = used[idx] ? tally[idx] : TALLY_ZERO;
      if (act == ACT_FIRST) begin
        if (cur != TALLY_MAX) cur = cur + 1'b1;
        len_first = bump_len(len_first);
      end else begin
        if (cur == TALLY_ZERO) went_negative = 1'b1;
        else cur = cur - 1'b1;
        len_second = bump_len(len_second);
      end
      tally[idx] = cur;
      used[idx]  = 1'b1;
    end
    if (act == ACT_SECOND && lst) begin
      v.is_permutation = !went_negative && !overflow && (len_first == len_second);
      v.too_long       = overflow;
      verdicts.push_back(v);
      clear_pair();
    end
  endfunction

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      clear_pair();
      verdicts.delete();
      mismatches = 0;
    end else begin
      // results trail their closing byte, so check before absorbing
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[1:0]);
        if (verdicts.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata %h", $time, out_tdata);
          mismatches++;
        end else begin
          want = verdicts.pop_front();
          if (got.is_permutation !== want.is_permutation) begin
            $display("%0t: is_permutation expected %0b, got %0b", $time,
                     want.is_permutation, got.is_permutation);
            mismatches++;
          end
          if (got.too_long !== want.too_long) begin
            $display("%0t: too_long expected %0b, got %0b", $time,
                     want.too_long, got.too_long);
            mismatches++;
          end
          if (out_tdata[7:2] !== 6'd0) begin
            $display("%0t: tdata padding expected 00, got %h", $time, out_tdata[7:2]);
            mismatches++;
          end
        end
      end
      if (in_tvalid && in_tready)
        tally_char(in_tuser[0], in_tdata, in_tuser[1], in_tlast);
    end
    awaiting = verdicts.size();
  end

endmodule

[tb/anagram_check_by_histogram_top_test.sv]
module anagram_check_by_histogram_top_test;
  import acgh_pkg::*;

  localparam int MAX_LEN     = 4096;
  localparam int ALPHABET    = 256;
  localparam int RANDOM_ITEMS = 1620;
  localparam int STALL_LIMIT = 2000;  // cycles without any transfer
  localparam int DRAIN       = 20;    // wait after the last predicted verdict

  typedef logic [7:0] char_q_t [$];

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] char_byte
  logic [1:0] in_tuser = 2'b00;   // [0] action, [1] has_char
  logic       in_tlast = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [0] is_permutation, [1] too_long, [7:2] zero

  int   mismatches;
  int   awaiting;
  int   sent = 0;
  int   stall_cycles = 0;
  logic calm = 1'b0;              // both sides stop idling while set

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  anagram_check_by_histogram_top #(
    .MAX_LEN (MAX_LEN),
    .ALPHABET(ALPHABET)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  anagram_verdict_monitor #(
    .MAX_LEN (MAX_LEN),
    .ALPHABET(ALPHABET)
  ) verdict_mon (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .mismatches(mismatches),
    .awaiting  (awaiting)
  );

  // Receiver: drop ready with a 23 percent chance, never during the calm stretch.
  always @(negedge clk) begin
    out_tready <= calm || ($urandom_range(99) >= 23);
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive one item at a falling edge, maybe after some idle cycles, and hold it
  // until the transfer completes. Leave valid high for the caller's next item.
  task automatic send_item(logic act, logic [7:0] ch, logic has, logic lst);
    if (!calm) begin
      while ($urandom_range(99) < 23) begin
        in_tvalid <= 1'b0;
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tuser  <= {has, act};
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  // Send one string; an empty one is a single item without a character.
  // With pad set, sprinkle characterless items and sometimes close with one.
  task automatic send_run(logic act, char_q_t s, logic pad);
    logic close_empty;
    close_empty = pad && ($urandom_range(9) == 0);
    if (s.size() == 0) begin
      send_item(act, 8'($urandom), 1'b0, 1'b1);
    end else begin
      for (int j = 0; j < s.size(); j++) begin
        if (pad && $urandom_range(19) == 0)
          send_item(act, 8'($urandom), 1'b0, 1'b0);
        send_item(act, s[j], 1'b1, (j == s.size() - 1) && !close_empty);
      end
      if (close_empty) send_item(act, 8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Short strings mostly; a narrow alphabet makes repeated characters likely.
  function automatic char_q_t pick_chars(int n);
    char_q_t    q;
    logic       narrow;
    logic [7:0] base;
    narrow = 1'($urandom_range(1));
    base   = 8'($urandom);
    repeat (n) q.push_back(narrow ? base + 8'($urandom_range(3)) : 8'($urandom));
    return q;
  endfunction

  // A first string and a shuffle of it, sometimes with one byte changed,
  // dropped or added.
  task automatic send_pair();
    char_q_t    a;
    char_q_t    b;
    logic [7:0] t;
    int         k;
    a = pick_chars(($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12));
    b = a;
    for (int j = b.size() - 1; j > 0; j--) begin
      k    = $urandom_range(j);
      t    = b[j];
      b[j] = b[k];
      b[k] = t;
    end
    case ($urandom_range(5))
      0: if (b.size() != 0) b[$urandom_range(b.size() - 1)] = 8'($urandom);
      1: if (b.size() != 0) b.delete($urandom_range(b.size() - 1));
      2: b.push_back(8'($urandom));
      default: ;
    endcase
    send_run(ACT_FIRST, a, 1'b1);
    send_run(ACT_SECOND, b, 1'b1);
  endtask

  // Sequences that break the usual first-then-second order.
  task automatic send_broken();
    char_q_t a;
    char_q_t b;
    a = pick_chars($urandom_range(1, 8));
    b = pick_chars($urandom_range(1, 8));
    case ($urandom_range(3))
      0: send_run(ACT_SECOND, b, 1'b1);           // second string alone
      1: begin                                    // two first strings
        send_run(ACT_FIRST, a, 1'b1);
        send_run(ACT_FIRST, b, 1'b1);
        send_run(ACT_SECOND, a, 1'b1);
      end
      2: begin                                    // stray first byte in the second
        send_run(ACT_FIRST, a, 1'b1);
        send_item(ACT_SECOND, a[0], 1'b1, 1'b0);
        send_item(ACT_FIRST, b[0], 1'b1, 1'($urandom_range(1)));
        send_run(ACT_SECOND, b, 1'b1);
      end
      default: begin                              // first string never closed
        foreach (a[j]) send_item(ACT_FIRST, a[j], 1'b1, 1'b0);
        send_run(ACT_SECOND, a, 1'b1);
      end
    endcase
  endtask

  initial begin
    char_q_t chars;
    int      base_count;
    int      kind;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty against empty.
    chars = {};
    send_run(ACT_FIRST, chars, 1'b0);
    send_run(ACT_SECOND, chars, 1'b0);
    // Extreme byte values, swapped.
    chars = {8'h00, 8'hFF};
    send_run(ACT_FIRST, chars, 1'b0);
    chars = {8'hFF, 8'h00};
    send_run(ACT_SECOND, chars, 1'b0);
    // Decrement of an untouched entry.
    chars = {8'h41};
    send_run(ACT_FIRST, chars, 1'b0);
    chars = {8'h42};
    send_run(ACT_SECOND, chars, 1'b0);
    // Same characters, different lengths.
    chars = {8'h41, 8'h41};
    send_run(ACT_FIRST, chars, 1'b0);
    chars = {8'h41};
    send_run(ACT_SECOND, chars, 1'b0);
    // Second string closed by a characterless item.
    send_item(ACT_FIRST, 8'h7E, 1'b1, 1'b1);
    send_item(ACT_SECOND, 8'h7E, 1'b1, 1'b0);
    send_item(ACT_SECOND, 8'h00, 1'b0, 1'b1);
    // Second-string byte before any first-string byte.
    send_item(ACT_SECOND, 8'h63, 1'b1, 1'b0);
    send_item(ACT_FIRST, 8'h63, 1'b1, 1'b1);
    send_item(ACT_SECOND, 8'h63, 1'b1, 1'b1);
    // First-string byte closing mid second string: still counts, no result.
    send_item(ACT_FIRST, 8'h10, 1'b1, 1'b1);
    send_item(ACT_SECOND, 8'h10, 1'b1, 1'b0);
    send_item(ACT_FIRST, 8'h20, 1'b1, 1'b1);
    send_item(ACT_SECOND, 8'h20, 1'b1, 1'b1);

    // Random: mostly well-formed pairs, some broken order, some pure noise.
    base_count = sent;
    while (sent - base_count < RANDOM_ITEMS) begin
      calm = (sent - base_count >= 600) && (sent - base_count < 900);
      kind = $urandom_range(99);
      if (kind < 70) begin
        send_pair();
      end else if (kind < 85) begin
        send_broken();
      end else begin
        repeat ($urandom_range(1, 6))
          send_item(1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)),
                    1'($urandom_range(1)));
      end
    end
    calm = 1'b0;
    in_tvalid <= 1'b0;

    // Drain: wait for every predicted verdict, then a few more cycles.
    while (awaiting != 0) @(negedge clk);
    repeat (DRAIN) @(negedge clk);

    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[anagram_check_by_histogram_top.f]
+incdir+rtl
rtl/acgh_pkg.sv
rtl/acgh_ram.sv
rtl/acgh_outq.sv
rtl/anagram_check_by_histogram_top.sv
rtl/acgh_checker.sv
tb/anagram_verdict_monitor.sv
tb/anagram_check_by_histogram_top_test.sv
